// File: rtl/wcsi_pkg.sv
package wcsi_pkg;

  typedef enum logic [1:0] {
    OP_CLEAR   = 2'd0,
    OP_PATTERN = 2'd1,
    OP_TEXT    = 2'd2,
    OP_FINISH  = 2'd3
  } op_t;

  localparam int unsigned CHAR_W = 16;
  localparam int unsigned POS_OUT_W = 16;

  typedef logic [CHAR_W-1:0] char_t;

  typedef struct packed {
    logic [POS_OUT_W-1:0] match_position;
    logic                 overflow;
  } result_t;

endpackage

// File: rtl/wcsi_search.sv
module wcsi_search #(
  parameter int unsigned PATTERN_MAX   = 16,
  parameter int unsigned POSITION_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  wcsi_pkg::op_t     op,
  input  wcsi_pkg::char_t   ch,
  output wcsi_pkg::result_t report
);

  localparam int unsigned LEN_W = $clog2(PATTERN_MAX + 1);
  localparam int unsigned WIDE_W = (POSITION_BITS > wcsi_pkg::POS_OUT_W) ?
                                   POSITION_BITS : wcsi_pkg::POS_OUT_W;
  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(PATTERN_MAX);
  localparam logic [POSITION_BITS-1:0] POS_LIMIT = '1;

  // Pattern held newest-first, so lane i lines up with window lane i.
  wcsi_pkg::char_t pattern_rev [PATTERN_MAX];
  wcsi_pkg::char_t text_window [PATTERN_MAX];
  wcsi_pkg::char_t window_next [PATTERN_MAX];

  logic [LEN_W-1:0]         pattern_length;
  logic [POSITION_BITS-1:0] text_count;
  logic [POSITION_BITS-1:0] text_count_next;
  logic [POSITION_BITS-1:0] found_start;
  logic                     pattern_over;
  logic                     text_over;
  logic                     text_over_next;
  logic [PATTERN_MAX-1:0]   lane_ok;
  logic                     window_hit;
  logic [POSITION_BITS-1:0] pos;
  logic [WIDE_W-1:0]        pos_wide;

  assign window_next[0] = ch;

  for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_lane
    if (i > 0) begin : g_shift
      assign window_next[i] = text_window[i-1];
    end
    assign lane_ok[i] = (LEN_W'(i) >= pattern_length) ||
                        (window_next[i] == pattern_rev[i]);
  end

  always_comb begin
    text_over_next  = text_over || (text_count == POS_LIMIT);
    text_count_next = (text_count == POS_LIMIT) ? POS_LIMIT : text_count + 1'b1;
    window_hit = (pattern_length != '0) &&
                 (text_count_next >= POSITION_BITS'(pattern_length)) &&
                 (&lane_ok);
  end

  always_ff @(posedge clk) begin
    if (step && op == wcsi_pkg::OP_TEXT) begin
      for (int k = 0; k < PATTERN_MAX; k++) begin
        text_window[k] <= window_next[k];
      end
    end
    if (step && op == wcsi_pkg::OP_PATTERN && pattern_length < LEN_MAX) begin
      pattern_rev[0] <= ch;
      for (int k = 1; k < PATTERN_MAX; k++) begin
        pattern_rev[k] <= pattern_rev[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_length <= '0;
      text_count     <= '0;
      found_start    <= '0;
      pattern_over   <= 1'b0;
      text_over      <= 1'b0;
    end else if (step) begin
      unique case (op)
        wcsi_pkg::OP_CLEAR: begin
          pattern_length <= '0;
          text_count     <= '0;
          found_start    <= '0;
          pattern_over   <= 1'b0;
          text_over      <= 1'b0;
        end
        wcsi_pkg::OP_PATTERN: begin
          if (pattern_length < LEN_MAX) begin
            pattern_length <= pattern_length + 1'b1;
          end else begin
            pattern_over <= 1'b1;
          end
        end
        wcsi_pkg::OP_TEXT: begin
          text_count <= text_count_next;
          text_over  <= text_over_next;
          if (found_start == '0 && window_hit) begin
            found_start <= text_over_next ? POS_LIMIT :
                           text_count_next - POSITION_BITS'(pattern_length) + 1'b1;
          end
        end
        wcsi_pkg::OP_FINISH: begin
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    if (pattern_over) begin
      pos = '0;
    end else if (pattern_length == '0) begin
      pos = POSITION_BITS'(text_count != '0);
    end else begin
      pos = found_start;
    end
    pos_wide = WIDE_W'(pos);
    report.match_position = pos_wide[wcsi_pkg::POS_OUT_W-1:0];
    report.overflow       = pattern_over || text_over;
  end

  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    pattern_length <= LEN_MAX)
    else $error("pattern length beyond store");

  a_found_holds: assert property (@(posedge clk) disable iff (rst)
    (found_start != '0 && !(step && op == wcsi_pkg::OP_CLEAR))
    |=> found_start == $past(found_start))
    else $error("recorded match start changed");

  a_text_over_sat: assert property (@(posedge clk) disable iff (rst)
    text_over |-> text_count == POS_LIMIT)
    else $error("text overflow without saturated count");

  a_found_after_text: assert property (@(posedge clk) disable iff (rst)
    found_start != '0 |-> text_count != '0)
    else $error("match recorded with no text");

endmodule

// File: rtl/wide_char_substring_index_unit.sv
// Streaming wide-character INDEX unit: takes one item per cycle unless stalled
// (clear, pattern character, text character, finish) and on finish returns the
// 1-based start of the first pattern match, 0 if none, plus an overflow flag.
// Each item is committed from the input register, and a finish result is loaded
// into the result register as its finish item leaves the input register.
// Throughput is one item per cycle, set by the combinational compare of all
// PATTERN_MAX window lanes against the stored pattern; a finish item waits in
// the input register only while an earlier result is held by result_stall.
module wide_char_substring_index_unit #(
  parameter int unsigned PATTERN_MAX   = 16,
  parameter int unsigned POSITION_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_stall,
  input  logic [1:0]  operation,
  input  logic [15:0] char_value,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [15:0] match_position,
  output logic        overflow
);

  logic              s1_valid;
  wcsi_pkg::op_t     s1_op;
  wcsi_pkg::char_t   s1_char;
  logic              result_free;
  logic              s1_advance;
  wcsi_pkg::result_t report;

  assign result_free = !result_valid || !result_stall;
  assign s1_advance  = s1_valid && (s1_op != wcsi_pkg::OP_FINISH || result_free);
  assign item_stall  = s1_valid && !s1_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!item_stall) begin
      s1_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!item_stall && item_valid) begin
      s1_op   <= wcsi_pkg::op_t'(operation);
      s1_char <= char_value;
    end
  end

  wcsi_search #(
    .PATTERN_MAX   (PATTERN_MAX),
    .POSITION_BITS (POSITION_BITS)
  ) u_search (
    .clk    (clk),
    .rst    (rst),
    .step   (s1_advance),
    .op     (s1_op),
    .ch     (s1_char),
    .report (report)
  );

  // Load the result on finish; drop it once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s1_advance && s1_op == wcsi_pkg::OP_FINISH) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance && s1_op == wcsi_pkg::OP_FINISH) begin
      match_position <= report.match_position;
      overflow       <= report.overflow;
    end
  end

  a_finish_loads: assert property (@(posedge clk) disable iff (rst)
    (s1_advance && s1_op == wcsi_pkg::OP_FINISH) |=> result_valid)
    else $error("finish item produced no result");

  a_blocked_holds: assert property (@(posedge clk) disable iff (rst)
    item_stall |=> s1_valid && s1_op == wcsi_pkg::OP_FINISH)
    else $error("stalled input register lost its item");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> result_valid && result_stall)
    else $error("input stalled with result register free");

endmodule

// File: sim/tb_wide_char_substring_index_unit.sv
`timescale 1ns / 100ps

module tb_wide_char_substring_index_unit;

  localparam int unsigned STORE_DEPTH = 16;
  localparam int unsigned POS_MAX = 65535;
  localparam int unsigned ITEM_TARGET = 1650;
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned HOLD_START = 400;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned QUIET_FIRST = 1000;
  localparam int unsigned QUIET_LAST = 1600;

  typedef struct {
    wcsi_pkg::op_t   op;
    wcsi_pkg::char_t ch;
  } item_t;

  logic  clk = 1'b0;
  logic  rst = 1'b1;
  logic  item_valid = 1'b0;
  logic  item_stall;
  wcsi_pkg::op_t   operation = wcsi_pkg::OP_CLEAR;
  wcsi_pkg::char_t char_value = '0;
  logic  result_valid;
  logic  result_stall = 1'b0;
  logic [15:0] match_position;
  logic  overflow;

  wide_char_substring_index_unit dut (
    .clk            (clk),
    .rst            (rst),
    .item_valid     (item_valid),
    .item_stall     (item_stall),
    .operation      (operation),
    .char_value     (char_value),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .match_position (match_position),
    .overflow       (overflow)
  );

  // Predicted block state
  wcsi_pkg::char_t pat_chars [STORE_DEPTH];
  int unsigned     pat_len;
  wcsi_pkg::char_t win_chars [STORE_DEPTH];
  int unsigned     txt_count;
  int unsigned     first_start;
  bit              ovf_seen;
  bit              pat_over;
  bit              txt_over;

  item_t             pending_items [$];
  wcsi_pkg::result_t expected_results [$];

  int unsigned cycle_count = 0;
  int unsigned hold_left = 0;
  int unsigned errors = 0;
  int unsigned items_accepted = 0;
  int unsigned text_accepted = 0;
  int unsigned results_checked = 0;
  int unsigned full_stalls = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    if (errors < 40)
      $display("MISMATCH at cycle %0d: %s got %0d, expected %0d", cycle_count, what, got,
               want);
    errors++;
  endtask

  task automatic clear_index();
    for (int k = 0; k < STORE_DEPTH; k++) begin
      pat_chars[k] = '0;
      win_chars[k] = '0;
    end
    pat_len = 0;
    txt_count = 0;
    first_start = 0;
    ovf_seen = 1'b0;
    pat_over = 1'b0;
    txt_over = 1'b0;
  endtask

  // Apply one accepted item; a finish queues the position it must report.
  task automatic index_step(input wcsi_pkg::op_t op, input wcsi_pkg::char_t ch);
    wcsi_pkg::result_t res;
    bit                hit;
    case (op)
      wcsi_pkg::OP_CLEAR: begin
        clear_index();
      end
      wcsi_pkg::OP_PATTERN: begin
        if (pat_len < STORE_DEPTH) begin
          pat_chars[pat_len] = ch;
          pat_len++;
        end else begin
          pat_over = 1'b1;
          ovf_seen = 1'b1;
        end
      end
      wcsi_pkg::OP_TEXT: begin
        for (int k = STORE_DEPTH - 1; k > 0; k--) win_chars[k] = win_chars[k-1];
        win_chars[0] = ch;
        if (txt_count >= POS_MAX) begin
          txt_count = POS_MAX;
          txt_over = 1'b1;
          ovf_seen = 1'b1;
        end else begin
          txt_count++;
        end
        hit = (pat_len != 0) && (txt_count >= pat_len);
        for (int j = 0; j < pat_len; j++)
          if (win_chars[pat_len-1-j] != pat_chars[j]) hit = 1'b0;
        if (first_start == 0 && hit)
          first_start = txt_over ? POS_MAX : txt_count - pat_len + 1;
      end
      wcsi_pkg::OP_FINISH: begin
        if (pat_over) res.match_position = '0;
        else if (pat_len == 0) res.match_position = (txt_count > 0) ? 16'd1 : 16'd0;
        else res.match_position = first_start[15:0];
        res.overflow = ovf_seen;
        expected_results.push_back(res);
      end
    endcase
  endtask

  task automatic push_item(input wcsi_pkg::op_t op, input wcsi_pkg::char_t ch);
    item_t it;
    it.op = op;
    it.ch = ch;
    pending_items.push_back(it);
  endtask

  function automatic bit take_break();
    if (cycle_count >= QUIET_FIRST && cycle_count < QUIET_LAST) return 1'b0;
    return $urandom_range(99) < 7;
  endfunction

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d items still queued", cycle_count,
               pending_items.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Long receiver hold-off so the block backs up into its input
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (cycle_count == HOLD_START) begin
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin : driver
    item_t nxt;
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      if (item_valid && !item_stall) begin
        index_step(operation, char_value);
        items_accepted++;
        if (operation == wcsi_pkg::OP_TEXT) text_accepted++;
      end
      if (item_valid && item_stall && hold_left != 0) full_stalls++;
      // hold a stalled item, otherwise offer the next one
      if (!item_valid || !item_stall) begin
        if (pending_items.size() != 0 && !take_break()) begin
          nxt = pending_items.pop_front();
          item_valid <= 1'b1;
          operation <= nxt.op;
          char_value <= nxt.ch;
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : monitor
    wcsi_pkg::result_t want;
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        results_checked++;
        if (expected_results.size() == 0) begin
          report_mismatch("result with none pending, match_position", 32'(match_position), 0);
        end else begin
          want = expected_results.pop_front();
          if (match_position !== want.match_position)
            report_mismatch("match_position", 32'(match_position),
                            32'(want.match_position));
          if (overflow !== want.overflow)
            report_mismatch("overflow", 32'(overflow), 32'(want.overflow));
        end
      end
      result_stall <= (hold_left != 0) || take_break();
    end
  end

  initial begin
    wcsi_pkg::char_t pat_buf [20];
    wcsi_pkg::char_t base;
    int    plen;
    int    tlen;
    int    ins;
    int    pick;

    clear_index();

    // fresh finish, empty pattern with and without text
    push_item(wcsi_pkg::OP_FINISH, 16'h1234);
    push_item(wcsi_pkg::OP_TEXT, 16'hFFFF);
    push_item(wcsi_pkg::OP_FINISH, 16'h0000);
    // simple match, repeated finish, text after the match was found
    push_item(wcsi_pkg::OP_CLEAR, 16'hFFFF);
    push_item(wcsi_pkg::OP_PATTERN, 16'hA5A5);
    push_item(wcsi_pkg::OP_PATTERN, 16'h5A5A);
    push_item(wcsi_pkg::OP_TEXT, 16'h0000);
    push_item(wcsi_pkg::OP_TEXT, 16'hA5A5);
    push_item(wcsi_pkg::OP_TEXT, 16'h5A5A);
    push_item(wcsi_pkg::OP_FINISH, 16'hFFFF);
    push_item(wcsi_pkg::OP_FINISH, 16'h0000);
    push_item(wcsi_pkg::OP_TEXT, 16'hA5A5);
    push_item(wcsi_pkg::OP_TEXT, 16'h5A5A);
    push_item(wcsi_pkg::OP_FINISH, 16'h8001);
    // pattern arriving after text only sees later text
    push_item(wcsi_pkg::OP_CLEAR, 16'h0000);
    push_item(wcsi_pkg::OP_TEXT, 16'h0001);
    push_item(wcsi_pkg::OP_PATTERN, 16'h0001);
    push_item(wcsi_pkg::OP_FINISH, 16'h0000);
    push_item(wcsi_pkg::OP_TEXT, 16'h0001);
    push_item(wcsi_pkg::OP_FINISH, 16'h0000);

    // Random sequences: mostly clear/pattern/text/finish, some broken or noise
    while (pending_items.size() < ITEM_TARGET) begin
      pick = $urandom_range(9);
      if (pick == 0) begin
        repeat ($urandom_range(1, 6))
          push_item(wcsi_pkg::op_t'($urandom_range(3)), wcsi_pkg::char_t'($urandom));
      end else begin
        // no clear: the sequence builds on whatever came before
        if (pick != 1) push_item(wcsi_pkg::OP_CLEAR, wcsi_pkg::char_t'($urandom));
        pick = $urandom_range(9);
        if (pick == 0) plen = 0;
        else if (pick <= 6) plen = $urandom_range(1, 4);
        else if (pick == 7) plen = STORE_DEPTH;
        else if (pick == 8) plen = $urandom_range(17, 20);
        else plen = $urandom_range(5, 15);
        base = wcsi_pkg::char_t'($urandom);
        for (int k = 0; k < plen; k++) begin
          pat_buf[k] = wcsi_pkg::char_t'(base + $urandom_range(2));
          push_item(wcsi_pkg::OP_PATTERN, pat_buf[k]);
        end
        tlen = $urandom_range(30);
        ins = ($urandom_range(1) == 1 && plen <= STORE_DEPTH) ? $urandom_range(tlen) : -1;
        for (int k = 0; k <= tlen; k++) begin
          if (k == ins)
            for (int j = 0; j < plen; j++) push_item(wcsi_pkg::OP_TEXT, pat_buf[j]);
          if (k < tlen)
            push_item(wcsi_pkg::OP_TEXT, wcsi_pkg::char_t'(base + $urandom_range(2)));
          if ($urandom_range(39) == 0)
            push_item(wcsi_pkg::OP_PATTERN, wcsi_pkg::char_t'(base + $urandom_range(2)));
        end
        push_item(wcsi_pkg::OP_FINISH, wcsi_pkg::char_t'($urandom));
        if ($urandom_range(3) == 0)
          push_item(wcsi_pkg::OP_FINISH, wcsi_pkg::char_t'($urandom));
      end
    end

    push_item(wcsi_pkg::OP_CLEAR, 16'h0000);
    push_item(wcsi_pkg::OP_FINISH, 16'h0000);

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    do @(posedge clk);
    while (pending_items.size() != 0 || item_valid || expected_results.size() != 0);
    repeat (20) @(posedge clk);

    $display("Run: %0d items accepted (%0d text characters), %0d reports checked", items_accepted,
             text_accepted, results_checked);
    $display("Covered overlong patterns, late pattern characters and %0d input stall cycles",
             full_stalls);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches", errors);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
